// File: src/quadratic_root_solver_macros.svh
// Assertion macros for the quadratic root solver.
`ifndef QUADRATIC_ROOT_SOLVER_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_MACROS_SVH

`ifndef SYNTHESIS
`define QRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define QRS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |=> post) else $error(msg);
`else
`define QRS_ASSERT(lbl, prop, msg)
`define QRS_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// File: src/qrs_pkg.sv
`default_nettype none
package qrs_pkg;

  localparam int unsigned CoefWidth      = 16;
  localparam int unsigned ResultFracBits = 16;
  localparam int unsigned ResultWidth    = 32;

  typedef enum logic [1:0] {
    KIND_TWO_REAL = 2'd0,
    KIND_DOUBLE   = 2'd1,
    KIND_COMPLEX  = 2'd2,
    KIND_DEGEN    = 2'd3
  } root_kind_e;

  // Per-stage control that travels alongside the data
  typedef struct packed {
    logic       valid;
    logic       azero;
    logic       aneg;
    logic       dneg;
    logic       dzero;
    root_kind_e kind;
    logic       neg1;
    logic       neg2;
  } flags_t;

endpackage
`default_nettype wire

// File: src/qrs_sqrt_cell.sv
`default_nettype none
// One bit of the square root: restoring digit step on two radicand bits.
module qrs_sqrt_cell #(
  parameter int unsigned CW = 16,
  parameter int unsigned RW = 66,
  parameter int unsigned SW = 33
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  en_i,
  input  qrs_pkg::flags_t      flags_i,
  input  wire signed [CW-1:0]  a_i,
  input  wire signed [CW-1:0]  b_i,
  input  wire        [RW-1:0]  rad_i,
  input  wire        [SW:0]    rem_i,
  input  wire        [SW-1:0]  root_i,
  output qrs_pkg::flags_t      flags_o,
  output logic signed [CW-1:0] a_o,
  output logic signed [CW-1:0] b_o,
  output logic        [RW-1:0] rad_o,
  output logic        [SW:0]   rem_o,
  output logic        [SW-1:0] root_o
);

  logic [SW+2:0] rem2;
  logic [SW+3:0] trial;
  logic [SW:0]   rem_d;
  logic [SW-1:0] root_d;
  qrs_pkg::flags_t flags_q;
  logic signed [CW-1:0] a_q, b_q;
  logic [RW-1:0] rad_q;
  logic [SW:0]   rem_q;
  logic [SW-1:0] root_q;

  always_comb begin
    rem2  = {rem_i, rad_i[RW-1:RW-2]};
    trial = {1'b0, rem2} - {2'b00, root_i, 2'b01};
    if (!trial[SW+3]) begin
      rem_d  = trial[SW:0];
      root_d = {root_i[SW-2:0], 1'b1};
    end else begin
      rem_d  = rem2[SW:0];
      root_d = {root_i[SW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (en_i) begin
      flags_q <= flags_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q    <= a_i;
      b_q    <= b_i;
      rad_q  <= {rad_i[RW-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign flags_o = flags_q;
  assign a_o     = a_q;
  assign b_o     = b_q;
  assign rad_o   = rad_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;

endmodule
`default_nettype wire

// File: src/qrs_div_cell.sv
`default_nettype none
// One quotient bit for both lanes of the restoring divider.
module qrs_div_cell #(
  parameter int unsigned CW = 16,
  parameter int unsigned MW = 36
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   en_i,
  input  qrs_pkg::flags_t       flags_i,
  input  wire        [CW:0]     den_i,
  input  wire  [1:0][MW-1:0]    num_i,
  input  wire  [1:0][CW:0]      rem_i,
  input  wire  [1:0][MW-1:0]    quo_i,
  output qrs_pkg::flags_t       flags_o,
  output logic       [CW:0]     den_o,
  output logic [1:0][MW-1:0]    num_o,
  output logic [1:0][CW:0]      rem_o,
  output logic [1:0][MW-1:0]    quo_o
);

  logic [1:0][CW+1:0] part;
  logic [1:0][CW+1:0] diff;
  logic [1:0][CW:0]   rem_d;
  logic [1:0][MW-1:0] quo_d;
  qrs_pkg::flags_t    flags_q;
  logic [CW:0]        den_q;
  logic [1:0][MW-1:0] num_q;
  logic [1:0][CW:0]   rem_q;
  logic [1:0][MW-1:0] quo_q;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      part[l] = {rem_i[l], num_i[l][MW-1]};
      diff[l] = part[l] - {1'b0, den_i};
      if (part[l] >= {1'b0, den_i}) begin
        rem_d[l] = diff[l][CW:0];
        quo_d[l] = {quo_i[l][MW-2:0], 1'b1};
      end else begin
        rem_d[l] = part[l][CW:0];
        quo_d[l] = {quo_i[l][MW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (en_i) begin
      flags_q <= flags_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q <= den_i;
      for (int l = 0; l < 2; l++) begin
        num_q[l] <= {num_i[l][MW-2:0], 1'b0};
      end
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign flags_o = flags_q;
  assign den_o   = den_q;
  assign num_o   = num_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;

endmodule
`default_nettype wire

// File: src/quadratic_root_solver.sv
`default_nettype none
// Quadratic root solver: takes one coefficient set (a, b, c) per clock and
// returns one result per set after capture, product and discriminant
// registers, S = COEF_WIDTH + RESULT_FRAC_BITS + 1 square-root cells, numerator
// and magnitude registers, M = COEF_WIDTH + RESULT_FRAC_BITS + 4 divider cells
// and an output register. The root chain yields one bit per cell and
// the divider one quotient bit per cell for both values at once. Sets are
// taken back to back; a stall at the output freezes the whole pipeline, and a
// skid register on the input holds one more set before in_stall_o rises.
module quadratic_root_solver #(
  parameter int unsigned COEF_WIDTH       = qrs_pkg::CoefWidth,
  parameter int unsigned RESULT_FRAC_BITS = qrs_pkg::ResultFracBits
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  wire signed [COEF_WIDTH-1:0]         coef_a_i,
  input  wire signed [COEF_WIDTH-1:0]         coef_b_i,
  input  wire signed [COEF_WIDTH-1:0]         coef_c_i,
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output logic [1:0]                          root_kind_o,
  output logic signed [qrs_pkg::ResultWidth-1:0] first_value_o,
  output logic signed [qrs_pkg::ResultWidth-1:0] second_value_o,
  output logic                                saturated_o
);

  localparam int unsigned CW = COEF_WIDTH;
  localparam int unsigned F  = RESULT_FRAC_BITS;
  localparam int unsigned RS = qrs_pkg::ResultWidth;
  localparam int unsigned DW = 2 * CW + 2;
  localparam int unsigned SW = CW + F + 1;
  localparam int unsigned RW = 2 * SW;
  localparam int unsigned NW = CW + F + 3;
  localparam int unsigned MW = NW + 1;
  localparam int unsigned XW = (MW > RS + 1) ? MW : RS + 1;

  localparam logic [XW-1:0] LimPos = {{(XW-RS+1){1'b0}}, {(RS-1){1'b1}}};
  localparam logic [XW-1:0] LimNeg = {{(XW-RS){1'b0}}, 1'b1, {(RS-1){1'b0}}};

  logic en;
  assign en = !(out_valid_o && out_stall_i);

  // Input skid
  logic skid_valid_q;
  logic signed [CW-1:0] skid_a_q, skid_b_q, skid_c_q;
  logic head_valid;
  logic signed [CW-1:0] head_a, head_b, head_c;

  assign in_stall_o = skid_valid_q;
  assign head_valid = skid_valid_q || in_valid_i;
  assign head_a = skid_valid_q ? skid_a_q : coef_a_i;
  assign head_b = skid_valid_q ? skid_b_q : coef_b_i;
  assign head_c = skid_valid_q ? skid_c_q : coef_c_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
    end else if (en) begin
      skid_valid_q <= 1'b0;
    end else if (in_valid_i && !skid_valid_q) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!en && in_valid_i && !skid_valid_q) begin
      skid_a_q <= coef_a_i;
      skid_b_q <= coef_b_i;
      skid_c_q <= coef_c_i;
    end
  end

  // Stage 1: capture, stage 2: products, stage 3: discriminant
  logic v1_q, v2_q;
  qrs_pkg::flags_t f3_q;
  logic signed [CW-1:0]   a1_q, b1_q, c1_q, a2_q, b2_q, a3_q, b3_q;
  logic signed [2*CW-1:0] ac2_q, bb2_q;
  logic signed [2*CW+2:0] disc;
  logic        [2*CW+2:0] disc_abs;
  logic        [RW-1:0]   rad3_q;
  qrs_pkg::flags_t f3_d;

  always_comb begin
    disc     = $signed({{3{bb2_q[2*CW-1]}}, bb2_q}) - $signed({ac2_q[2*CW-1], ac2_q, 2'b00});
    disc_abs = disc[2*CW+2] ? (0 - disc) : disc;
    f3_d        = '0;
    f3_d.valid  = v2_q;
    f3_d.azero  = (a2_q == '0);
    f3_d.aneg   = a2_q[CW-1];
    f3_d.dneg   = disc[2*CW+2];
    f3_d.dzero  = (disc == '0);
    f3_d.kind   = qrs_pkg::KIND_TWO_REAL;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      f3_q <= '0;
    end else if (en) begin
      v1_q <= head_valid;
      v2_q <= v1_q;
      f3_q <= f3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_q   <= head_a;
      b1_q   <= head_b;
      c1_q   <= head_c;
      ac2_q  <= a1_q * c1_q;
      bb2_q  <= b1_q * b1_q;
      a2_q   <= a1_q;
      b2_q   <= b1_q;
      a3_q   <= a2_q;
      b3_q   <= b2_q;
      rad3_q <= {disc_abs[DW-1:0], {(2*F){1'b0}}};
    end
  end

  // Square-root chain
  qrs_pkg::flags_t      sf [SW+1];
  logic signed [CW-1:0] sa [SW+1];
  logic signed [CW-1:0] sb [SW+1];
  logic [RW-1:0]        srad [SW+1];
  logic [SW:0]          srem [SW+1];
  logic [SW-1:0]        sroot [SW+1];

  assign sf[0]    = f3_q;
  assign sa[0]    = a3_q;
  assign sb[0]    = b3_q;
  assign srad[0]  = rad3_q;
  assign srem[0]  = '0;
  assign sroot[0] = '0;

  for (genvar i = 0; i < SW; i++) begin : g_sqrt
    qrs_sqrt_cell #(.CW(CW), .RW(RW), .SW(SW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .flags_i (sf[i]),
      .a_i     (sa[i]),
      .b_i     (sb[i]),
      .rad_i   (srad[i]),
      .rem_i   (srem[i]),
      .root_i  (sroot[i]),
      .flags_o (sf[i+1]),
      .a_o     (sa[i+1]),
      .b_o     (sb[i+1]),
      .rad_o   (srad[i+1]),
      .rem_o   (srem[i+1]),
      .root_o  (sroot[i+1])
    );
  end

  // Stage 4: numerators and classification
  logic signed [NW-1:0] base, sext, nplus, nminus;
  logic signed [1:0][NW-1:0] n4_d;
  qrs_pkg::flags_t f4_d, f4_q;
  logic signed [NW-1:0] n4_q [2];
  logic signed [CW-1:0] a4_q;

  always_comb begin
    base   = (NW'(0) - NW'(sb[SW])) <<< F;
    sext   = $signed({{(NW-SW){1'b0}}, sroot[SW]});
    nplus  = base + sext;
    nminus = base - sext;
    f4_d   = sf[SW];
    if (sf[SW].azero) begin
      f4_d.kind = qrs_pkg::KIND_DEGEN;
      n4_d[0]   = '0;
      n4_d[1]   = '0;
    end else if (sf[SW].dneg) begin
      f4_d.kind = qrs_pkg::KIND_COMPLEX;
      n4_d[0]   = base;
      n4_d[1]   = sext;
    end else if (sf[SW].dzero) begin
      f4_d.kind = qrs_pkg::KIND_DOUBLE;
      n4_d[0]   = base;
      n4_d[1]   = base;
    end else begin
      f4_d.kind = qrs_pkg::KIND_TWO_REAL;
      n4_d[0]   = sf[SW].aneg ? nminus : nplus;
      n4_d[1]   = sf[SW].aneg ? nplus : nminus;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f4_q <= '0;
    end else if (en) begin
      f4_q <= f4_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n4_q[0] <= n4_d[0];
      n4_q[1] <= n4_d[1];
      a4_q    <= sa[SW];
    end
  end

  // Stage 5: magnitudes with the rounding bias |a| added, signs, divisor 2|a|
  logic [CW-1:0] amag;
  logic [1:0][MW-1:0] mag5_d;
  qrs_pkg::flags_t f5_d, f5_q;
  logic [1:0][MW-1:0] num5_q;
  logic [CW:0] den5_q;
  logic [NW-1:0] nabs [2];

  always_comb begin
    amag = a4_q[CW-1] ? (CW'(0) - a4_q) : a4_q;
    f5_d = f4_q;
    for (int l = 0; l < 2; l++) begin
      nabs[l]   = n4_q[l][NW-1] ? (NW'(0) - n4_q[l]) : n4_q[l];
      mag5_d[l] = {1'b0, nabs[l]} + {{(MW-CW){1'b0}}, amag};
    end
    f5_d.neg1 = n4_q[0][NW-1] ^ f4_q.aneg;
    f5_d.neg2 = n4_q[1][NW-1] ^ f4_q.aneg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f5_q <= '0;
    end else if (en) begin
      f5_q <= f5_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num5_q <= mag5_d;
      den5_q <= {amag, 1'b0};
    end
  end

  // Divider chain
  qrs_pkg::flags_t    df [MW+1];
  logic [CW:0]        dden [MW+1];
  logic [1:0][MW-1:0] dnum [MW+1];
  logic [1:0][CW:0]   drem [MW+1];
  logic [1:0][MW-1:0] dquo [MW+1];

  assign df[0]   = f5_q;
  assign dden[0] = den5_q;
  assign dnum[0] = num5_q;
  assign drem[0] = '0;
  assign dquo[0] = '0;

  for (genvar j = 0; j < MW; j++) begin : g_div
    qrs_div_cell #(.CW(CW), .MW(MW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .flags_i (df[j]),
      .den_i   (dden[j]),
      .num_i   (dnum[j]),
      .rem_i   (drem[j]),
      .quo_i   (dquo[j]),
      .flags_o (df[j+1]),
      .den_o   (dden[j+1]),
      .num_o   (dnum[j+1]),
      .rem_o   (drem[j+1]),
      .quo_o   (dquo[j+1])
    );
  end

  // Output stage: sign, saturate, zero degenerate results
  logic [XW-1:0] qx [2];
  logic [1:0][RS-1:0] val;
  logic [1:0] lane_sat;
  logic [1:0] lane_neg;
  qrs_pkg::flags_t fo_q;
  logic [RS-1:0] v1_o_q, v2_o_q;
  logic sat_o_q;

  always_comb begin
    lane_neg = {df[MW].neg2, df[MW].neg1};
    for (int l = 0; l < 2; l++) begin
      qx[l] = XW'(dquo[MW][l]);
      if (lane_neg[l]) begin
        lane_sat[l] = (qx[l] > LimNeg);
        val[l]      = lane_sat[l] ? LimNeg[RS-1:0] : RS'(XW'(0) - qx[l]);
      end else begin
        lane_sat[l] = (qx[l] > LimPos);
        val[l]      = lane_sat[l] ? LimPos[RS-1:0] : qx[l][RS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fo_q <= '0;
    end else if (en) begin
      fo_q <= df[MW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (df[MW].kind == qrs_pkg::KIND_DEGEN) begin
        v1_o_q  <= '0;
        v2_o_q  <= '0;
        sat_o_q <= 1'b0;
      end else begin
        v1_o_q  <= val[0];
        v2_o_q  <= val[1];
        sat_o_q <= |lane_sat;
      end
    end
  end

  assign out_valid_o    = fo_q.valid;
  assign root_kind_o    = fo_q.kind;
  assign first_value_o  = v1_o_q;
  assign second_value_o = v2_o_q;
  assign saturated_o    = sat_o_q;

`include "quadratic_root_solver_macros.svh"

  `QRS_ASSERT(a_skid_fill, (skid_valid_q && !$past(skid_valid_q)) |-> $past(out_valid_o && out_stall_i), "skid filled without an output stall")
  `QRS_ASSERT(a_degen_zero, (out_valid_o && root_kind_o == qrs_pkg::KIND_DEGEN) |-> (first_value_o == '0 && second_value_o == '0 && !saturated_o), "degenerate result not zero")
  `QRS_ASSERT(a_double_eq, (out_valid_o && root_kind_o == qrs_pkg::KIND_DOUBLE) |-> (first_value_o == second_value_o), "double root values differ")
  `QRS_ASSERT_NEXT(a_skid_drain, (skid_valid_q && !(out_valid_o && out_stall_i)), !skid_valid_q, "skid not drained when pipeline advanced")

endmodule
`default_nettype wire

// File: tb/tb_quadratic_root_solver.sv
`default_nettype none
module tb_quadratic_root_solver;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = qrs_pkg::ResultFracBits;
  localparam int LATENCY = 74;
  localparam int NUM_RANDOM = 730;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    qrs_pkg::root_kind_e kind;
    logic [31:0] v1;
    logic [31:0] v2;
    logic        sat;
  } roots_t;

  typedef struct {
    logic signed [15:0] a, b, c;
    logic                known;
    roots_t              res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_stall_i = 1'b0;
  logic signed [15:0] coef_a_i = '0, coef_b_i = '0, coef_c_i = '0;
  logic in_stall_o, out_valid_o, saturated_o;
  logic [1:0] root_kind_o;
  logic signed [31:0] first_value_o, second_value_o;

  quadratic_root_solver dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  roots_t pending_roots[$];
  int     errors = 0;
  longint cycles = 0;
  bit     stim_done = 0;
  bit     hold_off = 0;

  // Round half away from zero, then clip to 32 bits.
  function automatic logic [31:0] div_round(longint num, longint den, inout logic sat);
    longint n, d, q;
    bit neg;
    n = num < 0 ? -num : num;
    d = den < 0 ? -den : den;
    q = (n + d / 2) / d;
    neg = (num < 0) != (den < 0);
    if (neg) begin
      if (q > 64'sd2147483648) begin sat = 1; q = 64'sd2147483648; end
      return 32'(-q);
    end
    if (q > 64'sd2147483647) begin sat = 1; q = 64'sd2147483647; end
    return 32'(q);
  endfunction

  function automatic logic [63:0] wide_root(logic [127:0] v);
    logic [63:0] r, t;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (128'(t) * 128'(t) <= v) r = t;
    end
    return r;
  endfunction

  function automatic roots_t solve_roots(logic signed [15:0] a, b, c);
    roots_t r;
    longint sa, sb, prod, den, base, s;
    logic signed [127:0] disc;
    logic [127:0] mag;
    logic [31:0] rp, rm;
    r.kind = qrs_pkg::KIND_DEGEN; r.v1 = '0; r.v2 = '0; r.sat = 0;
    if (a == 0) return r;
    sa = a; sb = b;
    prod = sa * longint'(c);
    disc = 128'(sb * sb) - 128'(4 * prod);
    mag = disc < 0 ? 128'(-disc) : 128'(disc);
    s = longint'(wide_root(mag << (2 * FRAC)));
    den = 2 * sa;
    base = -sb * (64'sd1 <<< FRAC);
    if (disc < 0) begin
      r.kind = qrs_pkg::KIND_COMPLEX;
      r.v1 = div_round(base, den, r.sat);
      r.v2 = div_round(s, den, r.sat);
    end else if (disc == 0) begin
      r.kind = qrs_pkg::KIND_DOUBLE;
      r.v1 = div_round(base, den, r.sat);
      r.v2 = r.v1;
    end else begin
      r.kind = qrs_pkg::KIND_TWO_REAL;
      rp = div_round(base + s, den, r.sat);
      rm = div_round(base - s, den, r.sat);
      if (a > 0) begin r.v1 = rp; r.v2 = rm; end
      else begin r.v1 = rm; r.v2 = rp; end
    end
    return r;
  endfunction

  function automatic row_t mk(int a, int b, int c, bit known = 0,
                              qrs_pkg::root_kind_e k = qrs_pkg::KIND_DEGEN,
                              int v1 = 0, int v2 = 0, bit sat = 0);
    row_t r;
    r.a = 16'(a); r.b = 16'(b); r.c = 16'(c);
    r.known = known;
    r.res.kind = k; r.res.v1 = 32'(v1); r.res.v2 = 32'(v2); r.res.sat = sat;
    return r;
  endfunction

  row_t directed[$];

  initial begin
    directed = '{
      mk(0, 0, 0, 1, qrs_pkg::KIND_DEGEN), mk(0, 32767, -32768, 1, qrs_pkg::KIND_DEGEN),
      mk(256, 0, 0, 1, qrs_pkg::KIND_DOUBLE, 0, 0),
      mk(256, 0, -256, 1, qrs_pkg::KIND_TWO_REAL, 65536, -65536),
      mk(-256, 0, 256, 1, qrs_pkg::KIND_TWO_REAL, 65536, -65536),
      mk(256, 0, 256, 1, qrs_pkg::KIND_COMPLEX, 0, 65536),
      mk(-256, 0, -256, 1, qrs_pkg::KIND_COMPLEX, 0, -65536),
      mk(1, -32768, 0), mk(1, 32767, 0), mk(-1, 32767, 32767),
      mk(1, 0, -32768), mk(1, 0, 32767), mk(-32768, -32768, -32768),
      mk(32767, 32767, 32767), mk(-32768, 32767, 32767), mk(32767, -32768, -32768),
      mk(256, -512, 256), mk(-1, 2, -1), mk(3, 7, -5), mk(-7, 3, 11),
      mk(1, 1, 1), mk(-1, -1, 32767), mk(16'hffff, 16'hffff, 16'hffff)
    };
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send(row_t r);
    int gap;
    if ($urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    coef_a_i <= r.a; coef_b_i <= r.b; coef_c_i <= r.c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_roots.push_back(r.known ? r.res : solve_roots(r.a, r.b, r.c));
  endtask

  function automatic logic signed [15:0] rnd_coef();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'(int'($urandom_range(0, 16)) - 8);
      2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      3: return 16'(int'($urandom_range(0, 1024)) - 512);
      default: return 16'(int'($urandom_range(0, 8191)) - 4096);
    endcase
  endfunction

  initial begin
    row_t r;
    int k;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) send(directed[i]);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      r = mk(0, 0, 0);
      r.a = rnd_coef(); r.b = rnd_coef(); r.c = rnd_coef();
      // Aim for double roots: b = 2ak with c = a*k*k.
      if ($urandom_range(0, 9) == 0) begin
        k = int'($urandom_range(0, 20)) - 10;
        r.a = 16'(int'($urandom_range(1, 60)) * ($urandom_range(0, 1) ? 1 : -1));
        r.b = 16'(2 * r.a * k);
        r.c = 16'(r.a * k * k);
      end
      if (i == 200) hold_off = 1;
      send(r);
    end
    in_valid_i <= 1'b0;
    stim_done = 1;
  end

  // Receiver stall: random gaps plus one long hold-off.
  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        hold_off = 0;
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
      end
      if ($urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                            : $urandom_range(1, 3)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    roots_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_roots.size() == 0) begin
        $display("%0t: unexpected transaction kind %0d", $time, root_kind_o);
        errors++;
      end else begin
        e = pending_roots.pop_front();
        if (root_kind_o !== e.kind || first_value_o !== e.v1 ||
            second_value_o !== e.v2 || saturated_o !== e.sat) begin
          $display("%0t: expected kind %0d v1 %h v2 %h sat %0b, got %0d %h %h %0b",
                   $time, e.kind, e.v1, e.v2, e.sat,
                   root_kind_o, first_value_o, second_value_o, saturated_o);
          errors++;
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    while (pending_roots.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 20) @(posedge clk_i);
    if (errors == 0 && pending_roots.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire
